>>> rtl/acws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acws_pkg: shared types and constants of the alarm clock with snooze
// Key bit positions, register indexes, reset values and the time-of-day type.
// ----------------------------------------------------------------------------
package acws_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_TICKS_PER_SEC = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SNOOZE_MIN    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FIRST_PITCH   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SECOND_PITCH  = 2'd3;

  // Register reset values
  localparam logic [7:0]  RST_TICKS_PER_SEC = 8'd61;
  localparam logic [5:0]  RST_SNOOZE_MIN    = 6'd9;
  localparam logic [15:0] RST_FIRST_PITCH   = 16'd20;
  localparam logic [15:0] RST_SECOND_PITCH  = 16'd25;

  // Key masks (keys active low at the pins, active high here)
  localparam logic [7:0] KEY_SEC  = 8'h01;
  localparam logic [7:0] KEY_MIN  = 8'h02;
  localparam logic [7:0] KEY_HOUR = 8'h20;
  localparam logic [7:0] KEY_MODE = 8'h40;
  localparam logic [7:0] KEY_ARM  = 8'h80;

  // Wrap limits
  localparam logic [4:0] LAST_HOUR = 5'd23;
  localparam logic [5:0] LAST_MIN  = 6'd59;
  localparam logic [5:0] LAST_SEC  = 6'd59;
  localparam logic [6:0] MIN_PER_H = 7'd60;

  // Operation codes
  localparam logic OP_PRESCALE = 1'b0;
  localparam logic OP_KEYSAMPLE = 1'b1;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } hms_t;

endpackage
`default_nettype wire

>>> rtl/alarm_clock_with_snooze.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alarm_clock_with_snooze: time-of-day clock with alarm, key debounce, snooze
// Prescaler and key-sample ticks update time, alarm, mode and buzzer state.
// ----------------------------------------------------------------------------
// Path: an input beat enters the input register, then one pass of update
//   logic writes the result register.
// Throughput: one beat per cycle unless out_ready_i holds the result register;
//   the state update loop on the clock, alarm and debounce registers is one pass.
// Reset: rst_ni low clears time, alarm, mode and press state, presets the debounce
//   counters and loads the register defaults; the block accepts beats right after reset.
module alarm_clock_with_snooze (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration writes
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [acws_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire  [acws_pkg::CfgDataW-1:0] cfg_data_i,
  // input beats
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          op_i,
  input  wire  [7:0]                   key_pins_i,
  input  wire                          motion_i,
  // result beats
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [4:0]                   hours_o,
  output logic [5:0]                   minutes_o,
  output logic [5:0]                   seconds_o,
  output logic [4:0]                   alarm_hours_o,
  output logic [5:0]                   alarm_minutes_o,
  output logic [5:0]                   alarm_seconds_o,
  output logic                         setting_alarm_o,
  output logic                         alarm_armed_o,
  output logic                         buzzer_on_o,
  output logic [15:0]                  pitch_o
);

  // --------------------------------------------------------------------------
  // Wrapping increments
  // --------------------------------------------------------------------------
  function automatic logic [4:0] bump_hour(input logic [4:0] h);
    return (h >= acws_pkg::LAST_HOUR) ? 5'd0 : h + 5'd1;
  endfunction

  function automatic acws_pkg::hms_t bump_minute(input acws_pkg::hms_t t);
    acws_pkg::hms_t r;
    r = t;
    if (t.minutes >= acws_pkg::LAST_MIN) begin
      r.minutes = 6'd0;
      r.hours   = bump_hour(t.hours);
    end else begin
      r.minutes = t.minutes + 6'd1;
    end
    return r;
  endfunction

  function automatic acws_pkg::hms_t bump_second(input acws_pkg::hms_t t);
    acws_pkg::hms_t r;
    r = t;
    if (t.seconds >= acws_pkg::LAST_SEC) begin
      r.seconds = 6'd0;
      r = bump_minute(r);
    end else begin
      r.seconds = t.seconds + 6'd1;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  ticks_per_sec_q;
  logic [5:0]  snooze_min_q;
  logic [15:0] first_pitch_q;
  logic [15:0] second_pitch_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_per_sec_q <= acws_pkg::RST_TICKS_PER_SEC;
      snooze_min_q    <= acws_pkg::RST_SNOOZE_MIN;
      first_pitch_q   <= acws_pkg::RST_FIRST_PITCH;
      second_pitch_q  <= acws_pkg::RST_SECOND_PITCH;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        acws_pkg::REG_TICKS_PER_SEC: ticks_per_sec_q <= cfg_data_i[7:0];
        acws_pkg::REG_SNOOZE_MIN:    snooze_min_q    <= cfg_data_i[5:0];
        acws_pkg::REG_FIRST_PITCH:   first_pitch_q   <= cfg_data_i;
        acws_pkg::REG_SECOND_PITCH:  second_pitch_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic       in_valid_q;
  logic       op_q;
  logic [7:0] pins_q;
  logic       motion_q;
  logic       step_fire;

  // advance when the result register is free or being drained
  assign step_fire  = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q     <= op_i;
      pins_q   <= key_pins_i;
      motion_q <= motion_i;
    end
  end

  // --------------------------------------------------------------------------
  // Clock state
  // --------------------------------------------------------------------------
  logic [7:0]      tick_cnt_q, tick_cnt_d;
  acws_pkg::hms_t  time_q, time_d;
  acws_pkg::hms_t  alarm_q, alarm_d;
  logic            set_mode_q, set_mode_d;
  logic            armed_q, armed_d;
  logic            note_q, note_d;
  logic [7:0]      deb_low_q, deb_low_d;
  logic [7:0]      deb_high_q, deb_high_d;
  logic [7:0]      stable_q, stable_d;
  logic [7:0]      pressed_q, pressed_d;
  logic            buzz_d;

  // single pass of the step update
  always_comb begin
    logic [7:0]     chg;
    logic [7:0]     chg_ok;
    logic [5:0]     snz_add;
    logic [6:0]     snz_sum;
    acws_pkg::hms_t adj;

    tick_cnt_d = tick_cnt_q;
    time_d     = time_q;
    alarm_d    = alarm_q;
    set_mode_d = set_mode_q;
    armed_d    = armed_q;
    note_d     = note_q;
    deb_low_d  = deb_low_q;
    deb_high_d = deb_high_q;
    stable_d   = stable_q;
    pressed_d  = pressed_q;
    buzz_d     = 1'b0;
    chg        = 8'd0;
    chg_ok     = 8'd0;
    snz_add    = 6'd0;
    snz_sum    = 7'd0;
    adj        = alarm_q;

    // tick work: prescaler or debounce
    if (op_q == acws_pkg::OP_PRESCALE) begin
      tick_cnt_d = tick_cnt_q + 8'd1;
      if (tick_cnt_d == ticks_per_sec_q) begin
        tick_cnt_d = 8'd0;
        time_d     = bump_second(time_q);
        note_d     = ~note_q;
      end
    end else begin
      chg        = ~pins_q ^ stable_q;
      deb_low_d  = ~(deb_low_q & chg);
      deb_high_d = deb_low_d ^ (deb_high_q & chg);
      chg_ok     = chg & deb_low_d & deb_high_d;
      stable_d   = stable_q ^ chg_ok;
      pressed_d  = pressed_q | (stable_d & chg_ok);
    end

    // consume presses: mode, arm, then minute, second, hour increments
    if ((pressed_d & acws_pkg::KEY_MODE) != 8'd0) set_mode_d = ~set_mode_d;
    if ((pressed_d & acws_pkg::KEY_ARM) != 8'd0)  armed_d    = ~armed_d;

    adj = set_mode_d ? alarm_d : time_d;
    if ((pressed_d & acws_pkg::KEY_MIN) != 8'd0)  adj = bump_minute(adj);
    if ((pressed_d & acws_pkg::KEY_SEC) != 8'd0)  adj = bump_second(adj);
    if ((pressed_d & acws_pkg::KEY_HOUR) != 8'd0) adj.hours = bump_hour(adj.hours);
    if (set_mode_d) begin
      alarm_d = adj;
    end else begin
      time_d = adj;
    end
    pressed_d = pressed_d & ~(acws_pkg::KEY_MODE | acws_pkg::KEY_ARM |
                              acws_pkg::KEY_MIN | acws_pkg::KEY_SEC | acws_pkg::KEY_HOUR);

    // restart the note pair at the top of each minute
    if (time_d.seconds == 6'd0) note_d = 1'b0;

    // alarm compare and snooze
    if (armed_d && (time_d.hours == alarm_d.hours) &&
        (time_d.minutes == alarm_d.minutes)) begin
      buzz_d = 1'b1;
      if (motion_q) begin
        snz_add = (snooze_min_q > acws_pkg::LAST_MIN) ? acws_pkg::LAST_MIN : snooze_min_q;
        snz_sum = {1'b0, alarm_d.minutes} + {1'b0, snz_add};
        if (snz_sum >= acws_pkg::MIN_PER_H) begin
          snz_sum       = snz_sum - acws_pkg::MIN_PER_H;
          alarm_d.hours = bump_hour(alarm_d.hours);
        end
        alarm_d.minutes = snz_sum[5:0];
      end
    end
  end

  // commit state on each processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_cnt_q <= 8'd0;
      time_q     <= '0;
      alarm_q    <= '0;
      set_mode_q <= 1'b0;
      armed_q    <= 1'b0;
      note_q     <= 1'b0;
      deb_low_q  <= 8'hFF;
      deb_high_q <= 8'hFF;
      stable_q   <= 8'd0;
      pressed_q  <= 8'd0;
    end else if (step_fire) begin
      tick_cnt_q <= tick_cnt_d;
      time_q     <= time_d;
      alarm_q    <= alarm_d;
      set_mode_q <= set_mode_d;
      armed_q    <= armed_d;
      note_q     <= note_d;
      deb_low_q  <= deb_low_d;
      deb_high_q <= deb_high_d;
      stable_q   <= stable_d;
      pressed_q  <= pressed_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (step_fire) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      hours_o         <= time_d.hours;
      minutes_o       <= time_d.minutes;
      seconds_o       <= time_d.seconds;
      alarm_hours_o   <= alarm_d.hours;
      alarm_minutes_o <= alarm_d.minutes;
      alarm_seconds_o <= alarm_d.seconds;
      setting_alarm_o <= set_mode_d;
      alarm_armed_o   <= armed_d;
      buzzer_on_o     <= buzz_d;
      pitch_o         <= note_d ? second_pitch_q : first_pitch_q;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (time_q.hours <= acws_pkg::LAST_HOUR) && (time_q.minutes <= acws_pkg::LAST_MIN) &&
    (time_q.seconds <= acws_pkg::LAST_SEC))
    else $error("time state out of range");

  a_alarm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (alarm_q.hours <= acws_pkg::LAST_HOUR) && (alarm_q.minutes <= acws_pkg::LAST_MIN) &&
    (alarm_q.seconds <= acws_pkg::LAST_SEC))
    else $error("alarm state out of range");

  a_buzz_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && buzzer_on_o) |-> alarm_armed_o)
    else $error("buzzer on while alarm disarmed");

  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> out_valid_o)
    else $error("processed beat produced no result");

  a_press_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pressed_q & (acws_pkg::KEY_MODE | acws_pkg::KEY_ARM | acws_pkg::KEY_MIN |
                  acws_pkg::KEY_SEC | acws_pkg::KEY_HOUR)) == 8'd0)
    else $error("active key press left unconsumed");

endmodule
`default_nettype wire
